@@ design/bms_pkg.sv @@
`default_nettype none

package bms_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS  = 30;
  localparam int WB_W          = 20;
  localparam logic [WB_W-1:0] WB_RESET = 20'd131072;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
  localparam logic [30:0]        HALF_PI_Q30  = 31'd1686629713;

  // pipeline stage map
  localparam int ST_PH   = 1;
  localparam int ST_ZY   = 2;
  localparam int ST_C0   = 3;
  localparam int ST_MAP  = ST_C0 + CORDIC_STEPS;
  localparam int TAN_QB  = 31;
  localparam int ST_D1   = ST_MAP + 1;
  localparam int ST_MUL1 = ST_D1 + TAN_QB;
  localparam int ST_MUL2 = ST_MUL1 + 1;
  localparam int ST_D2I  = ST_MUL2 + 1;
  localparam int YAW_QB  = 33;
  localparam int ST_D2   = ST_D2I + 1;
  localparam int ST_OUT  = ST_D2 + YAW_QB;
  localparam int NUM_STAGES = ST_OUT;

  typedef struct packed {
    logic [15:0]        time_step;
    logic signed [21:0] acceleration;
    logic signed [17:0] steer_angle;
    logic signed [31:0] speed;
    logic signed [31:0] heading;
    logic signed [31:0] y_position;
    logic signed [31:0] x_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] next_speed;
    logic signed [31:0] next_heading;
    logic signed [31:0] next_y_position;
    logic signed [31:0] next_x_position;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] yaw;
    logic signed [31:0] v;
    logic signed [21:0] acc;
    logic [15:0]        dt;
    logic signed [17:0] steer;
    logic [31:0]        ph;
    logic [1:0]         quad;
    logic signed [33:0] xy;
    logic signed [33:0] yy;
    logic signed [33:0] zy;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] zs;
    logic               sneg;
    logic               slsb;
    logic [32:0]        d1;
    logic [33:0]        rem1;
    logic [30:0]        q1;
    logic signed [33:0] wx;
    logic signed [33:0] wy;
    logic signed [33:0] w;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [22:0] dv;
    logic signed [34:0] wd;
    logic               wneg;
    logic [34:0]        wmag;
    logic               ovf;
    logic [20:0]        rem2;
    logic [32:0]        q2;
  } stage_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    case (i)
      0:       atan_q30 = 34'sd843314857;
      1:       atan_q30 = 34'sd497837829;
      2:       atan_q30 = 34'sd263043837;
      3:       atan_q30 = 34'sd133525159;
      4:       atan_q30 = 34'sd67021687;
      5:       atan_q30 = 34'sd33543516;
      6:       atan_q30 = 34'sd16775851;
      7:       atan_q30 = 34'sd8388437;
      8:       atan_q30 = 34'sd4194283;
      9:       atan_q30 = 34'sd2097149;
      default: atan_q30 = 34'sd1 <<< (30 - i);
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ design/bicycle_model_state_step.sv @@
// Kinematic bicycle model, one forward Euler step per transaction.
// Input stream (in_*): one vehicle state with steering angle, acceleration
// and time step per transaction. Output stream (out_*): the next state, one
// transaction for every input transaction, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into the wheel base register;
// write only while no transaction is in flight. Reset value is 2 m.
// Throughput: one transaction per clock while out_tready does not stall it.
// Depth: 102 register stages, from the input register to the one on out_tdata,
// set by the 30-step CORDICs (yaw and steering side by side), the
// 31-step tangent divider and the 33-step yaw-rate divider, each one step
// per pipeline stage, plus eight stages of setup, multiply and output.
// The whole pipeline advances together; when the receiver holds out_tready
// low with a result waiting, in_tready drops and every stage holds, so
// nothing is lost or repeated. Bubbles fill in as soon as out_tready returns.
// Reset (rst_n low, synchronous) clears all valid bits and restores the
// wheel base; payload registers are not reset.
`default_nettype none

module bicycle_model_state_step #(
  parameter int FRAC_BITS = bms_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // x_position, y_position, heading, speed, steer_angle, acceleration, time_step
  input  logic [183:0]                 in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // next_x_position, next_y_position, next_heading, next_speed
  output logic [127:0]                 out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [bms_pkg::WB_W-1:0]     cfg_wr_data
);
  import bms_pkg::*;

  logic [WB_W-1:0] axle_len_r;
  logic            en;
  out_item_t       out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_len_r <= WB_RESET;
    end else if (cfg_wr_en) begin
      axle_len_r <= cfg_wr_data;
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  bms_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_tvalid),
    .in_item    (in_item_t'(in_tdata)),
    .axle_len   (axle_len_r),
    .out_vld    (out_tvalid),
    .out_item   (out_item)
  );

  assign out_tdata = out_item;

endmodule

`default_nettype wire

@@ design/bms_pipe.sv @@
`default_nettype none

module bms_pipe #(
  parameter int FRAC_BITS = bms_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  bms_pkg::in_item_t             in_item,
  input  logic [bms_pkg::WB_W-1:0]      axle_len,
  output logic                          out_vld,
  output bms_pkg::out_item_t            out_item
);
  import bms_pkg::*;

  localparam int NW = 35 + FRAC_BITS;

  stage_t                st_r   [0:NUM_STAGES];
  stage_t                st_nxt [1:NUM_STAGES];
  stage_t                st0;
  logic [NUM_STAGES:0]   vld_r;
  logic [WB_W-1:0]       len;

  assign len = (axle_len == '0) ? WB_W'(1) : axle_len;

  always_comb begin
    st0       = '0;
    st0.px    = in_item.x_position;
    st0.py    = in_item.y_position;
    st0.yaw   = in_item.heading;
    st0.v     = in_item.speed;
    st0.acc   = in_item.acceleration;
    st0.dt    = in_item.time_step;
    st0.steer = in_item.steer_angle;
  end

  genvar k;
  generate
    for (k = 1; k <= NUM_STAGES; k++) begin : g_st
      if (k == ST_PH) begin : g_ph
        logic signed [63:0] prod;
        logic signed [32:0] sx;
        logic signed [32:0] lim;
        always_comb begin
          st_nxt[k] = st_r[k-1];
          prod = 64'(st_r[k-1].yaw) * 64'(TURN_PER_RAD);
          st_nxt[k].ph = prod[FRAC_BITS+31:FRAC_BITS];
          lim = 33'sd1 <<< FRAC_BITS;
          sx = 33'(st_r[k-1].steer);
          if (sx > lim) begin
            sx = lim;
          end
          if (sx < -lim) begin
            sx = -lim;
          end
          st_nxt[k].zs = 34'(sx) <<< (30 - FRAC_BITS);
          st_nxt[k].xy = CORDIC_GAIN;
          st_nxt[k].yy = '0;
          st_nxt[k].xs = CORDIC_GAIN;
          st_nxt[k].ys = '0;
        end
      end else if (k == ST_ZY) begin : g_zy
        logic [60:0] m;
        always_comb begin
          st_nxt[k] = st_r[k-1];
          m = 61'(st_r[k-1].ph[29:0]) * 61'(HALF_PI_Q30);
          st_nxt[k].zy = $signed(34'(m[60:30]));
          st_nxt[k].quad = st_r[k-1].ph[31:30];
        end
      end else if (k >= ST_C0 && k < ST_MAP) begin : g_cordic
        localparam int I = k - ST_C0;
        stage_t s;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          if (!s.zy[33]) begin
            st_nxt[k].xy = s.xy - (s.yy >>> I);
            st_nxt[k].yy = s.yy + (s.xy >>> I);
            st_nxt[k].zy = s.zy - atan_q30(I);
          end else begin
            st_nxt[k].xy = s.xy + (s.yy >>> I);
            st_nxt[k].yy = s.yy - (s.xy >>> I);
            st_nxt[k].zy = s.zy + atan_q30(I);
          end
          if (!s.zs[33]) begin
            st_nxt[k].xs = s.xs - (s.ys >>> I);
            st_nxt[k].ys = s.ys + (s.xs >>> I);
            st_nxt[k].zs = s.zs - atan_q30(I);
          end else begin
            st_nxt[k].xs = s.xs + (s.ys >>> I);
            st_nxt[k].ys = s.ys - (s.xs >>> I);
            st_nxt[k].zs = s.zs + atan_q30(I);
          end
        end
      end else if (k == ST_MAP) begin : g_map
        stage_t s;
        logic signed [33:0] cs;
        logic [33:0] sabs;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          case (s.quad)
            2'd0: begin
              st_nxt[k].xy = s.xy;
              st_nxt[k].yy = s.yy;
            end
            2'd1: begin
              st_nxt[k].xy = -s.yy;
              st_nxt[k].yy = s.xy;
            end
            2'd2: begin
              st_nxt[k].xy = -s.xy;
              st_nxt[k].yy = -s.yy;
            end
            default: begin
              st_nxt[k].xy = s.yy;
              st_nxt[k].yy = -s.xy;
            end
          endcase
          cs = (s.xs < 34'sd1) ? 34'sd1 : s.xs;
          sabs = s.ys[33] ? 34'(-s.ys) : 34'(s.ys);
          st_nxt[k].sneg = s.ys[33];
          st_nxt[k].slsb = sabs[0];
          st_nxt[k].d1   = cs[32:0];
          st_nxt[k].rem1 = sabs >> 1;
          st_nxt[k].q1   = '0;
        end
      end else if (k >= ST_D1 && k < ST_MUL1) begin : g_div1
        localparam int J = TAN_QB - 1 - (k - ST_D1);
        stage_t s;
        logic [33:0] r2;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          r2 = {s.rem1[32:0], (J == TAN_QB - 1) ? s.slsb : 1'b0};
          if (r2 >= 34'(s.d1)) begin
            st_nxt[k].rem1 = r2 - 34'(s.d1);
            st_nxt[k].q1[J] = 1'b1;
          end else begin
            st_nxt[k].rem1 = r2;
          end
        end
      end else if (k == ST_MUL1) begin : g_mul1
        stage_t s;
        logic signed [31:0] tq;
        logic signed [63:0] pw;
        logic signed [65:0] pcx;
        logic signed [65:0] pcy;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          tq  = s.sneg ? -$signed({1'b0, s.q1}) : $signed({1'b0, s.q1});
          pw  = 64'(s.v) * 64'(tq);
          pcx = 66'(s.v) * 66'(s.xy);
          pcy = 66'(s.v) * 66'(s.yy);
          st_nxt[k].w  = 34'(pw >>> 30);
          st_nxt[k].wx = 34'(pcx >>> 30);
          st_nxt[k].wy = 34'(pcy >>> 30);
        end
      end else if (k == ST_MUL2) begin : g_mul2
        stage_t s;
        logic signed [16:0] dts;
        logic signed [50:0] px;
        logic signed [50:0] py;
        logic signed [50:0] pw;
        logic signed [38:0] pa;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          dts = $signed({1'b0, s.dt});
          px = 51'(s.wx) * 51'(dts);
          py = 51'(s.wy) * 51'(dts);
          pw = 51'(s.w) * 51'(dts);
          pa = 39'(s.acc) * 39'(dts);
          st_nxt[k].dx = 35'(px >>> 16);
          st_nxt[k].dy = 35'(py >>> 16);
          st_nxt[k].wd = 35'(pw >>> 16);
          st_nxt[k].dv = 23'(pa >>> 16);
        end
      end else if (k == ST_D2I) begin : g_d2i
        stage_t s;
        logic [34:0] mag;
        logic [NW-1:0] n;
        logic [NW-1:0] top;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          mag = s.wd[34] ? 35'(-s.wd) : 35'(s.wd);
          n   = {mag, {FRAC_BITS{1'b0}}};
          top = n >> YAW_QB;
          st_nxt[k].wneg = s.wd[34];
          st_nxt[k].wmag = mag;
          st_nxt[k].ovf  = (top >= NW'(len));
          st_nxt[k].rem2 = 21'(top);
          st_nxt[k].q2   = '0;
        end
      end else if (k >= ST_D2 && k < ST_OUT) begin : g_div2
        localparam int J = YAW_QB - 1 - (k - ST_D2);
        stage_t s;
        logic nb;
        logic [21:0] r2;
        if (J >= FRAC_BITS) begin : g_bit
          assign nb = st_r[k-1].wmag[J-FRAC_BITS];
        end else begin : g_zero
          assign nb = 1'b0;
        end
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          r2 = {s.rem2, nb};
          if (r2 >= 22'(len)) begin
            st_nxt[k].rem2 = 21'(r2 - 22'(len));
            st_nxt[k].q2[J] = 1'b1;
          end else begin
            st_nxt[k].rem2 = r2[20:0];
          end
        end
      end else begin : g_out
        stage_t s;
        logic signed [35:0] dmag;
        logic signed [35:0] dyaw;
        always_comb begin
          s = st_r[k-1];
          st_nxt[k] = s;
          dmag = s.ovf ? (36'sd1 <<< YAW_QB) : $signed(36'(s.q2));
          dyaw = s.wneg ? -dmag : dmag;
          st_nxt[k].px  = sat32(40'(s.px) + 40'(s.dx));
          st_nxt[k].py  = sat32(40'(s.py) + 40'(s.dy));
          st_nxt[k].yaw = sat32(40'(s.yaw) + 40'(dyaw));
          st_nxt[k].v   = sat32(40'(s.v) + 40'(s.dv));
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0;
      for (int i = 1; i <= NUM_STAGES; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STAGES-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[NUM_STAGES];

  always_comb begin
    out_item.next_x_position = st_r[NUM_STAGES].px;
    out_item.next_y_position = st_r[NUM_STAGES].py;
    out_item.next_heading    = st_r[NUM_STAGES].yaw;
    out_item.next_speed      = st_r[NUM_STAGES].v;
  end

endmodule

`default_nettype wire
